FILE: hw/rtl/emdh_pkg.sv
`default_nettype none

package emdh_pkg;

    localparam int RING_DAYS_DEF = 32;
    localparam int WEEK_DAYS     = 7;
    localparam int MONTH_DAYS    = 30;
    localparam int WALK_CNT_W    = $clog2(MONTH_DAYS + 1);

    localparam int KWH_UNITS     = 360000;
    localparam int ACC_W         = 19;
    localparam int KMOD_TOP      = 999;
    localparam int MWH_MAX       = 32767;
    localparam int WH_MUL        = 45;

    localparam logic [15:0] DATE_LO = 16'h0101;
    localparam logic [15:0] DATE_HI = 16'h1231;

    localparam int SUM_W         = 21;
    localparam int PROD_W        = SUM_W + 16;
    localparam int WEEK_AVG_K    = 65535 / 7;
    localparam int MONTH_TENTH_K = 65535 / 10;
    localparam int MONTH_AVG_K   = 65535 / 30;

    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 136;

    typedef enum logic [1:0] {
        MUL_WEEK_AVG,
        MUL_MONTH_TENTH,
        MUL_MONTH_AVG,
        MUL_DRAIN
    } mul_step_t;

    typedef struct packed {
        logic      take;
        logic      store;
        logic      rd_issue;
        logic      rd_first;
        logic      dat_proc;
        logic      dat_first;
        logic      week_mark;
        logic      mul_en;
        mul_step_t mul_step;
        logic      out_load;
    } emdh_cmd_t;

    typedef struct packed {
        logic out_free;
    } emdh_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/energy_meter_daily_history.sv
// An input goes through STORE, WALK and MUL to OUT, which loads m_tdata and raises
// m_tvalid, waiting while m_tready is low. A new input is taken only back in IDLE,
// after the walk over 30 ring entries through the single read port of the day ring.
// Reset (aresetn low, synchronous): counters, date, day pointer and all ring
// entries read as blank at once; no clearing pass.
`default_nettype none

module energy_meter_daily_history
    import emdh_pkg::*;
#(
    parameter int RING_DAYS = RING_DAYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // power_tenths_kw[15:0], today_date[31:16], clear_totals[32], zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // watt_hours_partial[9:0], kwh_within_mwh[19:10], mwh_count[34:20],
    // kwh_today_count[50:35], kwh_yesterday_count[65:51], week_total[81:66],
    // week_average[97:82], month_total_tenth[113:98], month_average[129:114],
    // week_valid[130], month_valid[131], zero pad
    output logic [M_TDATA_W-1:0]       m_tdata
);

    emdh_cmd_t    cmd;
    emdh_status_t status;

    emdh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    emdh_datapath #(
        .RING_DAYS (RING_DAYS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .power_tenths_kw (signed'(s_tdata[15:0])),
        .today_date      (s_tdata[31:16]),
        .clear_totals    (s_tdata[32]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_tdata         (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/emdh_ctrl.sv
`default_nettype none

module emdh_ctrl
    import emdh_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire emdh_status_t status,
    output emdh_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_WALK,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [WALK_CNT_W-1:0]   cnt_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_WALK;
                end
                ST_WALK: begin
                    if (cnt_reg == WALK_CNT_W'(MONTH_DAYS)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (mul_step_t'(cnt_reg[1:0]) == MUL_DRAIN) begin
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_step = mul_step_t'(cnt_reg[1:0]);
        unique case (state_reg)
            ST_IDLE:  cmd.take  = s_tvalid;
            ST_STORE: cmd.store = 1'b1;
            ST_WALK: begin
                cmd.rd_issue  = (cnt_reg < WALK_CNT_W'(MONTH_DAYS));
                cmd.rd_first  = (cnt_reg == '0);
                cmd.dat_proc  = (cnt_reg != '0);
                cmd.dat_first = (cnt_reg == WALK_CNT_W'(1));
                cmd.week_mark = (cnt_reg == WALK_CNT_W'(WEEK_DAYS));
            end
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_OUT:   cmd.out_load = status.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/emdh_datapath.sv
`default_nettype none

module emdh_datapath
    import emdh_pkg::*;
#(
    parameter int RING_DAYS = RING_DAYS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire emdh_cmd_t            cmd,
    output emdh_status_t              status,
    input  wire logic signed [15:0]   power_tenths_kw,
    input  wire logic [15:0]          today_date,
    input  wire logic                 clear_totals,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = $clog2(RING_DAYS);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        idx_inc = (i == AW'(RING_DAYS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        idx_dec = (i == '0) ? AW'(RING_DAYS - 1) : i - 1'b1;
    endfunction

    logic [31:0]              ring_mem [RING_DAYS];
    logic [RING_DAYS-1:0]     ring_vld_reg;
    logic [RING_DAYS-1:0]     ring_vld_next;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_snap_reg;
    logic [15:0]              today_reg;
    logic [9:0]               kmod_reg;
    logic [14:0]              mwh_reg;
    logic [AW-1:0]            ptr_reg;
    logic [15:0]              cur_date_reg;
    logic [15:0]              date_in_reg;

    logic [AW-1:0]            rd_addr_reg;
    logic [AW-1:0]            rd_addr_next;
    logic [AW-1:0]            y_addr_reg;
    logic [31:0]              rd_q_reg;
    logic                     rd_vld_reg;

    logic [14:0]              yest_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     ok_reg;
    logic                     ok_next;
    logic signed [SUM_W-1:0]  week_sum_reg;
    logic                     week_ok_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [15:0]              week_avg_reg;
    logic [15:0]              month_tenth_reg;
    logic [15:0]              month_avg_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TDATA_W-1:0]     out_word;

    logic signed [19:0]       acc_sum;
    logic signed [19:0]       acc_up;
    logic signed [19:0]       acc_dn;
    logic                     over;
    logic                     under;
    logic [ACC_W-1:0]         acc_next;
    logic [15:0]              today_next;
    logic [9:0]               kmod_next;
    logic [14:0]              mwh_next;

    logic [15:0]              e_date;
    logic [15:0]              e_kwh;
    logic                     e_ok;
    logic signed [SUM_W-1:0]  e_val;
    logic                     clamp;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [31:0]              wr_data;

    logic signed [SUM_W-1:0]  mul_a;
    logic signed [15:0]       mul_k;
    logic [22:0]              wh_prod;

    // integrate one tick and count kWh up or down
    assign acc_sum = signed'({1'b0, acc_reg}) + 20'(power_tenths_kw);
    assign over    = !acc_sum[19] && (acc_sum[ACC_W-1:0] > ACC_W'(KWH_UNITS));
    assign under   = acc_sum[19];
    assign acc_up  = acc_sum - 20'(KWH_UNITS);
    assign acc_dn  = acc_sum + 20'(KWH_UNITS);

    always_comb begin
        acc_next   = acc_sum[ACC_W-1:0];
        today_next = today_reg;
        kmod_next  = kmod_reg;
        mwh_next   = mwh_reg;
        priority if (over) begin
            acc_next   = (acc_up[ACC_W-1:0] > ACC_W'(KWH_UNITS)) ? '0 : acc_up[ACC_W-1:0];
            today_next = today_reg + 1'b1;
            if (kmod_reg >= 10'(KMOD_TOP)) begin
                kmod_next = '0;
                if (mwh_reg < 15'(MWH_MAX)) begin
                    mwh_next = mwh_reg + 1'b1;
                end
            end else begin
                kmod_next = kmod_reg + 1'b1;
            end
        end else if (under) begin
            acc_next   = acc_dn[19] ? '0 : acc_dn[ACC_W-1:0];
            today_next = today_reg - 1'b1;
            if (kmod_reg == '0) begin
                if (mwh_reg != '0) begin
                    kmod_next = 10'(KMOD_TOP);
                    mwh_next  = mwh_reg - 1'b1;
                end
            end else begin
                kmod_next = kmod_reg - 1'b1;
            end
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // mark today's entry written, blank the one after the new day
    always_comb begin
        ring_vld_next          = ring_vld_reg;
        ring_vld_next[ptr_reg] = 1'b1;
        if (date_in_reg != cur_date_reg) begin
            ring_vld_next[idx_inc(idx_inc(ptr_reg))] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            today_reg    <= '0;
            kmod_reg     <= '0;
            mwh_reg      <= '0;
            ptr_reg      <= '0;
            cur_date_reg <= '0;
            ring_vld_reg <= '0;
        end else if (cmd.take) begin
            if (clear_totals) begin
                acc_reg      <= '0;
                today_reg    <= '0;
                kmod_reg     <= '0;
                mwh_reg      <= '0;
                ptr_reg      <= '0;
                ring_vld_reg <= '0;
            end else begin
                acc_reg   <= acc_next;
                today_reg <= today_next;
                kmod_reg  <= kmod_next;
                mwh_reg   <= mwh_next;
            end
        end else if (cmd.store) begin
            ring_vld_reg <= ring_vld_next;
            if (date_in_reg != cur_date_reg) begin
                cur_date_reg <= date_in_reg;
                today_reg    <= '0;
                ptr_reg      <= idx_inc(ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            acc_snap_reg <= acc_next;
            date_in_reg  <= today_date;
        end
    end

    // ring entry as read, blank where never written since the last clear
    assign e_date = rd_vld_reg ? rd_q_reg[31:16] : '0;
    assign e_kwh  = rd_vld_reg ? rd_q_reg[15:0]  : '0;
    assign e_ok   = (e_date >= DATE_LO) && (e_date <= DATE_HI);
    assign clamp  = (e_date != '0) && e_kwh[15];
    assign e_val  = SUM_W'(signed'(e_kwh));

    assign wr_en   = cmd.store || (cmd.dat_first && clamp);
    assign wr_addr = cmd.store ? ptr_reg : y_addr_reg;
    assign wr_data = cmd.store ? {cur_date_reg, today_reg} : {e_date, 16'h0000};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_addr_next = cmd.rd_first ? idx_dec(ptr_reg) : idx_dec(rd_addr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rd_addr_reg <= rd_addr_next;
            rd_q_reg    <= ring_mem[rd_addr_next];
            rd_vld_reg  <= ring_vld_reg[rd_addr_next];
            if (cmd.rd_first) begin
                y_addr_reg <= rd_addr_next;
            end
        end
    end

    always_comb begin
        if (cmd.dat_first) begin
            ok_next  = e_ok;
            sum_next = (e_ok && !clamp) ? e_val : '0;
        end else begin
            ok_next  = ok_reg && e_ok;
            sum_next = e_ok ? sum_reg + e_val : sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dat_proc) begin
            sum_reg <= sum_next;
            ok_reg  <= ok_next;
            if (cmd.dat_first) begin
                yest_reg <= (clamp || (e_date == '0)) ? '0 : e_kwh[14:0];
            end
            if (cmd.week_mark) begin
                week_sum_reg <= sum_next;
                week_ok_reg  <= ok_next;
            end
        end
    end

    // one shared multiplier, product registered before the shift
    always_comb begin
        unique case (cmd.mul_step)
            MUL_WEEK_AVG: begin
                mul_a = week_sum_reg;
                mul_k = 16'(WEEK_AVG_K);
            end
            MUL_MONTH_TENTH: begin
                mul_a = sum_reg;
                mul_k = 16'(MONTH_TENTH_K);
            end
            MUL_MONTH_AVG: begin
                mul_a = sum_reg;
                mul_k = 16'(MONTH_AVG_K);
            end
            default: begin
                mul_a = sum_reg;
                mul_k = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_k);
            unique case (cmd.mul_step)
                MUL_WEEK_AVG:    ;
                MUL_MONTH_TENTH: week_avg_reg    <= prod_reg[31:16];
                MUL_MONTH_AVG:   month_tenth_reg <= prod_reg[31:16];
                MUL_DRAIN:       month_avg_reg   <= prod_reg[31:16];
                default:         ;
            endcase
        end
    end

    assign wh_prod = 23'(acc_snap_reg[ACC_W-1:2]) * 23'(WH_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        out_word          = '0;
        out_word[9:0]     = wh_prod[21:12];
        out_word[19:10]   = kmod_reg;
        out_word[34:20]   = mwh_reg;
        out_word[50:35]   = today_reg;
        out_word[65:51]   = yest_reg;
        if (week_ok_reg) begin
            out_word[81:66] = week_sum_reg[15:0];
            out_word[97:82] = week_avg_reg;
            out_word[130]   = 1'b1;
            if (ok_reg) begin
                out_word[113:98]  = month_tenth_reg;
                out_word[129:114] = month_avg_reg;
                out_word[131]     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

`default_nettype wire
